[src/crcorr_pkg.sv]
// ----------------------------------------------------------------------------
// crcorr_pkg
// Shared constants, types and cell control bundle for the complex replica
// correlator.
// ----------------------------------------------------------------------------
`default_nettype none

package crcorr_pkg;

    localparam int MAX_TAPS        = 64;
    localparam int SAMPLE_BITS     = 16;
    localparam int SAMPLE_W        = 16;
    localparam int TAP_W           = 16;
    localparam int ACC_W           = 38;
    localparam int LAG_W           = 16;
    localparam int LEN_W           = 7;
    localparam int OP_W            = 2;
    localparam int TAP_IDX_FIELD_W = 6;

    localparam int TAP_IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W     = $clog2(MAX_TAPS + 1);
    localparam int CMP_W     = (LEN_W > CNT_W) ? LEN_W : CNT_W;
    localparam int PROD_W    = SAMPLE_BITS + TAP_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_SEL_W  = APB_ADDR_W - 2;

    localparam logic [REG_SEL_W-1:0] REG_TAP_COUNT = '0;
    localparam logic [LEN_W-1:0]     LEN_RESET     = LEN_W'(1);

    typedef logic [OP_W-1:0] opcode_t;

    localparam opcode_t OP_LOAD_TAP = 2'd0;
    localparam opcode_t OP_PUSH     = 2'd1;
    localparam opcode_t OP_RESTART  = 2'd2;

    localparam logic [LAG_W-1:0] LAG_MAX = {LAG_W{1'b1}};

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [ACC_W-1:0]       acc_t;

    typedef struct packed {
        logic signed [TAP_W-1:0] re;
        logic signed [TAP_W-1:0] im;
    } cplx_t;

    typedef struct packed {
        logic                 push;
        logic                 restart;
        logic                 tap_we;
        logic [TAP_IDX_W-1:0] tap_addr;
        cplx_t                tap;
        logic                 load_work;
        logic                 shift_work;
        logic                 clear_sum;
        logic                 accum;
    } cell_ctl_t;

endpackage

`default_nettype wire

[src/crcorr_cell.sv]
// ----------------------------------------------------------------------------
// crcorr_cell
// One correlator cell: a history sample, a stored replica tap, a working tap
// that moves down the chain, and a partial sum that moves toward cell zero.
// ----------------------------------------------------------------------------
`default_nettype none

module crcorr_cell import crcorr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_ctl_t            ctl,
    input  logic [TAP_IDX_W-1:0] tap_pos,
    input  sample_t              hist_in,
    output sample_t              hist_out,
    input  cplx_t                work_in,
    output cplx_t                work_out,
    input  acc_t                 sum_re_in,
    input  acc_t                 sum_im_in,
    output acc_t                 sum_re_out,
    output acc_t                 sum_im_out
);

    sample_t hist_reg, hist_next;
    cplx_t   tap_reg, tap_next;
    cplx_t   work_reg, work_next;
    acc_t    sum_re_reg, sum_re_next;
    acc_t    sum_im_reg, sum_im_next;

    logic signed [PROD_W-1:0] prod_re;
    logic signed [PROD_W-1:0] prod_im;

    assign prod_re = hist_reg * $signed(work_reg.re);
    assign prod_im = hist_reg * $signed(work_reg.im);

    always_comb
    begin
        hist_next   = hist_reg;
        tap_next    = tap_reg;
        work_next   = work_reg;
        sum_re_next = sum_re_reg;
        sum_im_next = sum_im_reg;

        if (ctl.restart)
        begin
            hist_next = '0;
        end
        else if (ctl.push)
        begin
            hist_next = hist_in;
        end

        if (ctl.tap_we && (ctl.tap_addr == tap_pos))
        begin
            tap_next = ctl.tap;
        end

        if (ctl.load_work)
        begin
            work_next = tap_reg;
        end
        else if (ctl.shift_work)
        begin
            work_next = work_in;
        end

        if (ctl.clear_sum)
        begin
            sum_re_next = '0;
            sum_im_next = '0;
        end
        else if (ctl.accum)
        begin
            sum_re_next = sum_re_in + ACC_W'(prod_re);
            sum_im_next = sum_im_in - ACC_W'(prod_im);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg   <= '0;
            tap_reg    <= '0;
            work_reg   <= '0;
            sum_re_reg <= '0;
            sum_im_reg <= '0;
        end
        else
        begin
            hist_reg   <= hist_next;
            tap_reg    <= tap_next;
            work_reg   <= work_next;
            sum_re_reg <= sum_re_next;
            sum_im_reg <= sum_im_next;
        end
    end

    assign hist_out   = hist_reg;
    assign work_out   = work_reg;
    assign sum_re_out = sum_re_reg;
    assign sum_im_out = sum_im_reg;

endmodule

`default_nettype wire

[src/crcorr_ctrl.sv]
// ----------------------------------------------------------------------------
// crcorr_ctrl
// Opcode decode, fill and lag counters, sequencing of the cell chain and
// the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crcorr_ctrl import crcorr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  opcode_t                    opcode,
    input  logic [TAP_IDX_FIELD_W-1:0] tap_index,
    input  logic signed [TAP_W-1:0]    tap_real,
    input  logic signed [TAP_W-1:0]    tap_imag,
    input  logic [LEN_W-1:0]           tap_count,
    input  acc_t                       sum_re,
    input  acc_t                       sum_im,
    output cell_ctl_t                  ctl,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic signed [ACC_W-1:0]    corr_real,
    output logic signed [ACC_W-1:0]    corr_imag,
    output logic [LAG_W-1:0]           lag_index
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SHIFT = 4'b0010,
        ST_SUM   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [LAG_W-1:0]   lag_reg, lag_next;
    logic [LAG_W-1:0]   lag_hold_reg, lag_hold_next;
    logic               valid_reg, valid_next;
    acc_t               re_reg, re_next;
    acc_t               im_reg, im_next;
    logic [LAG_W-1:0]   lag_out_reg, lag_out_next;

    logic [CMP_W-1:0]   len_wide;
    logic [CNT_W-1:0]   eff_len;
    logic [CNT_W-1:0]   shift_amt;
    logic [CNT_W-1:0]   fill_inc;
    logic               accept;

    assign len_wide  = CMP_W'(tap_count);
    assign eff_len   = (len_wide == '0) ? CNT_W'(1) :
                       (len_wide > CMP_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) :
                       CNT_W'(len_wide);
    assign shift_amt = CNT_W'(MAX_TAPS) - eff_len;
    assign fill_inc  = (fill_reg < CNT_W'(MAX_TAPS)) ? fill_reg + 1'b1 : fill_reg;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        fill_next     = fill_reg;
        lag_next      = lag_reg;
        lag_hold_next = lag_hold_reg;
        valid_next    = valid_reg;
        re_next       = re_reg;
        im_next       = im_reg;
        lag_out_next  = lag_out_reg;

        ctl          = '0;
        ctl.tap_addr = TAP_IDX_W'(tap_index);
        ctl.tap.re   = tap_real;
        ctl.tap.im   = tap_imag;

        if (valid_reg && result_ready)
        begin
            valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        OP_LOAD_TAP:
                        begin
                            ctl.tap_we = (32'(tap_index) < MAX_TAPS);
                        end
                        OP_PUSH:
                        begin
                            ctl.push  = 1'b1;
                            fill_next = fill_inc;
                            if (fill_inc >= eff_len)
                            begin
                                ctl.load_work = 1'b1;
                                ctl.clear_sum = 1'b1;
                                lag_hold_next = lag_reg;
                                if (lag_reg != LAG_MAX)
                                begin
                                    lag_next = lag_reg + 1'b1;
                                end
                                if (shift_amt == '0)
                                begin
                                    cnt_next   = eff_len;
                                    state_next = ST_SUM;
                                end
                                else
                                begin
                                    cnt_next   = shift_amt;
                                    state_next = ST_SHIFT;
                                end
                            end
                        end
                        OP_RESTART:
                        begin
                            ctl.restart = 1'b1;
                            fill_next   = '0;
                            lag_next    = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SHIFT:
            begin
                ctl.shift_work = 1'b1;
                cnt_next       = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    cnt_next   = eff_len;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                ctl.accum = 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!valid_reg || result_ready)
                begin
                    valid_next   = 1'b1;
                    re_next      = sum_re;
                    im_next      = sum_im;
                    lag_out_next = lag_hold_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            fill_reg  <= '0;
            lag_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fill_reg  <= fill_next;
            lag_reg   <= lag_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lag_hold_reg <= lag_hold_next;
        re_reg       <= re_next;
        im_reg       <= im_next;
        lag_out_reg  <= lag_out_next;
    end

    assign result_valid = valid_reg;
    assign corr_real    = re_reg;
    assign corr_imag    = im_reg;
    assign lag_index    = lag_out_reg;

endmodule

`default_nettype wire

[src/complex_replica_correlator.sv]
// ----------------------------------------------------------------------------
// complex_replica_correlator
// Matched-filter correlation of a real sample stream against a stored
// complex replica, computed on a chain of tap cells.
// Timing: a push that completes a window runs the tap alignment shift
//   (ST_SHIFT), the partial-sum ripple through the cell chain (ST_SUM) and
//   ST_DONE, which loads the result output register once it is free.
// Throughput: further words wait until the result is registered; loads,
//   restarts and pushes without a result are taken one per cycle while idle.
// Reset: taps, history and counters clear at once, the tap count reads 1.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_replica_correlator import crcorr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,

    input  logic                       item_valid,
    output logic                       item_ready,
    input  logic [OP_W-1:0]            opcode,
    input  logic [TAP_IDX_FIELD_W-1:0] tap_index,
    input  logic signed [TAP_W-1:0]    tap_real,
    input  logic signed [TAP_W-1:0]    tap_imag,
    input  logic signed [SAMPLE_W-1:0] sample_value,

    output logic                       result_valid,
    input  logic                       result_ready,
    output logic signed [ACC_W-1:0]    corr_real,
    output logic signed [ACC_W-1:0]    corr_imag,
    output logic [LAG_W-1:0]           lag_index
);

    logic [LEN_W-1:0] len_reg, len_next;
    logic             reg_write;
    logic             sel_len;

    cell_ctl_t ctl;
    sample_t   sample_in;
    sample_t   hist_q [MAX_TAPS];
    cplx_t     work_c [MAX_TAPS+1];
    acc_t      sum_re_c [MAX_TAPS+1];
    acc_t      sum_im_c [MAX_TAPS+1];

    // register file
    assign pready    = 1'b1;
    assign sel_len   = (paddr[APB_ADDR_W-1:2] == REG_TAP_COUNT);
    assign reg_write = psel && penable && pwrite && pready;
    assign len_next  = (reg_write && sel_len) ? pwdata[LEN_W-1:0] : len_reg;
    assign prdata    = sel_len ? APB_DATA_W'(len_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    crcorr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (opcode),
        .tap_index    (tap_index),
        .tap_real     (tap_real),
        .tap_imag     (tap_imag),
        .tap_count    (len_reg),
        .sum_re       (sum_re_c[0]),
        .sum_im       (sum_im_c[0]),
        .ctl          (ctl),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .corr_real    (corr_real),
        .corr_imag    (corr_imag),
        .lag_index    (lag_index)
    );

    assign sample_in          = SAMPLE_BITS'(sample_value);
    assign work_c[MAX_TAPS]   = '0;
    assign sum_re_c[MAX_TAPS] = '0;
    assign sum_im_c[MAX_TAPS] = '0;

    // cell j holds history age j and replica tap MAX_TAPS-1-j
    for (genvar j = 0; j < MAX_TAPS; j++)
    begin : g_cell
        sample_t hist_feed;

        if (j == 0)
        begin : g_head
            assign hist_feed = sample_in;
        end
        else
        begin : g_body
            assign hist_feed = hist_q[j-1];
        end

        crcorr_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .tap_pos    (TAP_IDX_W'(MAX_TAPS - 1 - j)),
            .hist_in    (hist_feed),
            .hist_out   (hist_q[j]),
            .work_in    (work_c[j+1]),
            .work_out   (work_c[j]),
            .sum_re_in  (sum_re_c[j+1]),
            .sum_im_in  (sum_im_c[j+1]),
            .sum_re_out (sum_re_c[j]),
            .sum_im_out (sum_im_c[j])
        );
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.push, ctl.restart, ctl.tap_we}))
        else $error("more than one cell command at once");

    a_start_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_work |-> (ctl.push && ctl.clear_sum))
        else $error("lag computation started without a pushed sample");

    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.shift_work || ctl.accum) |-> !item_ready)
        else $error("word taken while the cell chain is busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_work |=> !item_ready)
        else $error("no busy period after a lag computation start");

endmodule

`default_nettype wire

[bench/complex_replica_correlator_tb.sv]
// ----------------------------------------------------------------------------
// complex_replica_correlator_tb
// Self-checking bench for the complex replica correlator. A short table of
// directed words covers the sample and tap extremes, every opcode, restarts,
// out-of-range lengths and length changes while the history is filled. Rows
// whose result is obvious carry it inline. The rest, and a long random run in
// phases of different replica lengths, are checked against an in-bench
// correlator. The sender idles in bursts and the receiver stalls on a pattern
// of its own.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_replica_correlator_tb;
    import crcorr_pkg::*;

    localparam opcode_t OP_UNUSED     = 2'd3;
    localparam int      SETTLE_CYCLES = 80;
    localparam int      CYCLE_LIMIT   = 400000;
    localparam int      RANDOM_WORDS  = 650;
    localparam int      DIR_ROWS      = 25;
    localparam int      EDGE_LENS [6] = '{127, 64, 0, 65, 1, 2};

    typedef struct packed {
        acc_t             re;
        acc_t             im;
        logic [LAG_W-1:0] lag;
    } corr_t;

    typedef struct {
        bit      cfg;
        int      len;
        opcode_t op;
        int      idx;
        int      re;
        int      im;
        int      smp;
        bit      typed;
        longint  exp_re;
        longint  exp_im;
        int      exp_lag;
    } vec_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0]      paddr   = '0;
    logic [APB_DATA_W-1:0]      pwdata  = '0;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;

    logic                       item_valid   = 1'b0;
    logic                       item_ready;
    logic [OP_W-1:0]            opcode       = '0;
    logic [TAP_IDX_FIELD_W-1:0] tap_index    = '0;
    logic signed [TAP_W-1:0]    tap_real     = '0;
    logic signed [TAP_W-1:0]    tap_imag     = '0;
    logic signed [SAMPLE_W-1:0] sample_value = '0;

    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic signed [ACC_W-1:0]    corr_real;
    logic signed [ACC_W-1:0]    corr_imag;
    logic [LAG_W-1:0]           lag_index;

    complex_replica_correlator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (opcode),
        .tap_index    (tap_index),
        .tap_real     (tap_real),
        .tap_imag     (tap_imag),
        .sample_value (sample_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .corr_real    (corr_real),
        .corr_imag    (corr_imag),
        .lag_index    (lag_index)
    );

    // bench copy of the correlator state
    logic signed [TAP_W-1:0] tap_re [MAX_TAPS];
    logic signed [TAP_W-1:0] tap_im [MAX_TAPS];
    sample_t                 history [MAX_TAPS];
    int                      fill_cnt;
    int                      lag_cnt;
    logic [LEN_W-1:0]        cur_len;

    corr_t pending_corr [$];
    int    err_count;
    int    cycle_count;
    int    burst_left;

    int    ready_mode;
    int    mode_left;
    int    run_left;
    bit    stalled;
    corr_t want;

    vec_t dir_tab [DIR_ROWS] = '{
        '{0, 0, OP_PUSH,     0,      0,      0,  32767, 1,           0,           0, 0},
        '{0, 0, OP_LOAD_TAP, 0, -32768,  32767,      0, 0,           0,           0, 0},
        '{0, 0, OP_PUSH,     0,      0,      0, -32768, 1,  1073741824,  1073709056, 1},
        '{0, 0, OP_PUSH,     0,      0,      0,  32767, 1, -1073709056, -1073676289, 2},
        '{0, 0, OP_UNUSED,  17,   1234,  -999,     77, 0,           0,           0, 0},
        '{0, 0, OP_RESTART,  0,      0,      0,      0, 0,           0,           0, 0},
        '{0, 0, OP_PUSH,     0,      0,      0,      1, 1,      -32768,      -32767, 0},
        '{0, 0, OP_LOAD_TAP, 1,  32767, -32768,      0, 0,           0,           0, 0},
        '{0, 0, OP_LOAD_TAP, 2,     -1,      1,      0, 0,           0,           0, 0},
        '{0, 0, OP_LOAD_TAP, 63, 32767,  32767,      0, 0,           0,           0, 0},
        '{1, 3, OP_PUSH,     0,      0,      0,      0, 0,           0,           0, 0},
        '{0, 0, OP_PUSH,     0,      0,      0, -32768, 0,           0,           0, 0},
        '{0, 0, OP_PUSH,     0,      0,      0,  32767, 0,           0,           0, 0},
        '{0, 0, OP_PUSH,     0,      0,      0,      0, 0,           0,           0, 0},
        '{0, 0, OP_RESTART,  0,      0,      0,      0, 0,           0,           0, 0},
        '{0, 0, OP_PUSH,     0,      0,      0,     -1, 0,           0,           0, 0},
        '{0, 0, OP_UNUSED,  63,     -1,     -1,     -1, 0,           0,           0, 0},
        '{0, 0, OP_PUSH,     0,      0,      0,  12345, 0,           0,           0, 0},
        '{0, 0, OP_PUSH,     0,      0,      0, -32768, 0,           0,           0, 0},
        '{1, 0, OP_PUSH,     0,      0,      0,      0, 0,           0,           0, 0},
        '{0, 0, OP_PUSH,     0,      0,      0,  32767, 0,           0,           0, 0},
        '{1, 127, OP_PUSH,   0,      0,      0,      0, 0,           0,           0, 0},
        '{0, 0, OP_PUSH,     0,      0,      0,      5, 0,           0,           0, 0},
        '{1, 2, OP_PUSH,     0,      0,      0,      0, 0,           0,           0, 0},
        '{0, 0, OP_PUSH,     0,      0,      0,     -7, 0,           0,           0, 0}
    };

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void flag_mismatch(input string msg);
        if (err_count < 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endfunction

    function automatic logic signed [15:0] q15_pick();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'shffff;
            3: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void clear_signal();
        foreach (history[i])
            history[i] = '0;
        fill_cnt = 0;
        lag_cnt  = 0;
    endfunction

    // applies one accepted word to the bench state, returns the lag result if any
    function automatic void advance_correlator(input opcode_t op, input logic [5:0] idx,
                                               input logic signed [15:0] re,
                                               input logic signed [15:0] im,
                                               input logic signed [15:0] smp,
                                               output bit got, output corr_t res);
        int     eff;
        longint sum_re;
        longint sum_im;
        got    = 1'b0;
        res    = '0;
        sum_re = 0;
        sum_im = 0;
        case (op)
            OP_LOAD_TAP:
            begin
                tap_re[idx] = re;
                tap_im[idx] = im;
            end
            OP_RESTART:
                clear_signal();
            OP_PUSH:
            begin
                for (int i = MAX_TAPS - 1; i > 0; i--)
                    history[i] = history[i-1];
                history[0] = smp;
                if (fill_cnt < MAX_TAPS)
                    fill_cnt++;
                eff = (cur_len == 0) ? 1 : (cur_len > MAX_TAPS) ? MAX_TAPS : int'(cur_len);
                if (fill_cnt >= eff)
                begin
                    for (int k = 0; k < eff; k++)
                    begin
                        sum_re += longint'(history[eff-1-k]) * longint'(tap_re[k]);
                        sum_im -= longint'(history[eff-1-k]) * longint'(tap_im[k]);
                    end
                    got     = 1'b1;
                    res.re  = acc_t'(sum_re);
                    res.im  = acc_t'(sum_im);
                    res.lag = LAG_W'(lag_cnt);
                    if (lag_cnt < int'(LAG_MAX))
                        lag_cnt++;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_word(input opcode_t op, input logic [5:0] idx,
                             input logic signed [15:0] re, input logic signed [15:0] im,
                             input logic signed [15:0] smp, input bit typed,
                             input corr_t typed_res);
        int    gap;
        bit    got;
        corr_t res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid   <= 1'b1;
        opcode       <= op;
        tap_index    <= idx;
        tap_real     <= re;
        tap_imag     <= im;
        sample_value <= smp;
        do @(posedge clk); while (!(item_valid && item_ready));
        advance_correlator(op, idx, re, im, smp, got, res);
        if (got)
            pending_corr.push_back(typed ? typed_res : res);
    endtask

    // waits until every lag result is back and the chain has drained
    task automatic settle();
        item_valid <= 1'b0;
        burst_left = 0;
        while (pending_corr.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_tap_count(input logic [LEN_W-1:0] len);
        logic [APB_DATA_W-1:0] word;
        settle();
        word = $urandom;
        word[LEN_W-1:0] = len;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TAP_COUNT, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        cur_len = len;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[LEN_W-1:0] !== len)
            flag_mismatch($sformatf("tap count read exp %0d got %0d",
                                    len, prdata[LEN_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: check, then pick the next stall pattern step
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_corr.size() == 0)
                flag_mismatch($sformatf("unexpected word re %0d im %0d lag %0d",
                                        corr_real, corr_imag, lag_index));
            else
            begin
                want = pending_corr.pop_front();
                if (corr_real !== want.re || corr_imag !== want.im || lag_index !== want.lag)
                    flag_mismatch($sformatf("re exp %0d got %0d, im exp %0d got %0d, lag exp %0d got %0d",
                                            want.re, corr_real, want.im, corr_imag,
                                            want.lag, lag_index));
            end
        end
        if (mode_left == 0)
        begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(30, 200);
        end
        mode_left--;
        case (ready_mode)
            0: result_ready <= 1'b1;
            1: result_ready <= 1'($urandom_range(0, 1));
            default:
            begin
                if (run_left == 0)
                begin
                    stalled  = !stalled;
                    run_left = stalled ? $urandom_range(1, 25) : $urandom_range(1, 6);
                end
                run_left--;
                result_ready <= !stalled;
            end
        endcase
    end

    initial
    begin
        int    counted;
        int    phase;
        int    eff;
        int    quota;
        int    pick;
        int    len;
        corr_t typed_res;

        foreach (tap_re[i])
        begin
            tap_re[i] = '0;
            tap_im[i] = '0;
        end
        clear_signal();
        cur_len     = LEN_RESET;
        err_count   = 0;
        cycle_count = 0;
        burst_left  = 0;
        ready_mode  = 0;
        mode_left   = 0;
        run_left    = 0;
        stalled     = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].cfg)
                set_tap_count(LEN_W'(dir_tab[i].len));
            else
            begin
                typed_res.re  = acc_t'(dir_tab[i].exp_re);
                typed_res.im  = acc_t'(dir_tab[i].exp_im);
                typed_res.lag = LAG_W'(dir_tab[i].exp_lag);
                send_word(dir_tab[i].op, 6'(dir_tab[i].idx), 16'(dir_tab[i].re),
                          16'(dir_tab[i].im), 16'(dir_tab[i].smp), dir_tab[i].typed,
                          typed_res);
            end
        end

        counted = 0;
        phase   = 0;
        while (counted < RANDOM_WORDS)
        begin
            if (phase < 6)
                len = EDGE_LENS[phase];
            else if ($urandom_range(0, 4) == 0)
                len = $urandom_range(0, 127);
            else
                len = $urandom_range(1, 10);
            set_tap_count(LEN_W'(len));
            eff = (len == 0) ? 1 : (len > MAX_TAPS) ? MAX_TAPS : len;

            if ($urandom_range(0, 1) == 1)
            begin
                send_word(OP_RESTART, 6'($urandom), q15_pick(), q15_pick(), q15_pick(),
                          1'b0, '0);
                counted++;
            end
            // fresh replica over the taps in use
            if ($urandom_range(0, 2) != 0)
                for (int k = 0; k < eff; k++)
                begin
                    send_word(OP_LOAD_TAP, 6'(k), q15_pick(), q15_pick(), q15_pick(),
                              1'b0, '0);
                    counted++;
                end

            quota = 40 + eff;
            for (int n = 0; n < quota; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    send_word(OP_UNUSED, 6'($urandom), q15_pick(), q15_pick(), q15_pick(),
                              1'b0, '0);
                else
                begin
                    if (pick < 5 || (pick < 7 && eff <= 16))
                        send_word(OP_RESTART, 6'($urandom), q15_pick(), q15_pick(),
                                  q15_pick(), 1'b0, '0);
                    else if (pick < 22)
                        send_word(OP_LOAD_TAP,
                                  ($urandom_range(0, 4) == 0) ? 6'($urandom)
                                                              : 6'($urandom_range(0, eff - 1)),
                                  q15_pick(), q15_pick(), q15_pick(), 1'b0, '0);
                    else
                        send_word(OP_PUSH, 6'($urandom), q15_pick(), q15_pick(), q15_pick(),
                                  1'b0, '0);
                    counted++;
                end
            end
            phase++;
        end

        settle();
        if (err_count == 0 && pending_corr.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
